// ----- hdl/ssm_pkg.sv -----
// ssm_pkg: word types, comparator modes, microcode fields and the control store
// for the selection sort block. Depends on nothing; the core and the checker import it.
package ssm_pkg;

  localparam int SSM_DEPTH = 32;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } ssm_in_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               final_res;
  } ssm_out_t;

  // order_mode codes
  localparam logic [1:0] MODE_DESC     = 2'd0;
  localparam logic [1:0] MODE_ASC      = 2'd1;
  localparam logic [1:0] MODE_MAG_DESC = 2'd2;
  localparam logic [1:0] MODE_MAG_ASC  = 2'd3;

  typedef enum logic [2:0] {
    RD_I, RD_J, RD_JNX, RD_K, RD_EMIT
  } ssm_rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE, WR_LOAD, WR_BEST, WR_SWAPBACK
  } ssm_wr_sel_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_INIT, OP_OUTER, OP_FETCH, OP_SCAN, OP_SWAP, OP_EMIT
  } ssm_op_t;

  typedef enum logic [2:0] {
    C_NEVER, C_TAKE_LAST, C_SHORT, C_SCAN_END, C_MORE, C_EMIT_END
  } ssm_cond_t;

  typedef logic [3:0] ssm_step_t;

  localparam ssm_step_t ST_IDLE   = 4'd0;
  localparam ssm_step_t ST_INIT   = 4'd1;
  localparam ssm_step_t ST_OUTER  = 4'd2;
  localparam ssm_step_t ST_FETCH  = 4'd3;
  localparam ssm_step_t ST_SCAN   = 4'd4;
  localparam ssm_step_t ST_SWAP_A = 4'd5;
  localparam ssm_step_t ST_SWAP_B = 4'd6;
  localparam ssm_step_t ST_EMIT0  = 4'd7;
  localparam ssm_step_t ST_EMIT   = 4'd8;

  // one control word: when cond holds go to target, else stay (hold) or advance
  typedef struct packed {
    logic        take;
    ssm_rd_sel_t rd_sel;
    ssm_wr_sel_t wr_sel;
    ssm_op_t     op;
    ssm_cond_t   cond;
    logic        hold;
    ssm_step_t   target;
  } ssm_ctrl_t;

  function automatic ssm_ctrl_t ssm_ucode(input ssm_step_t step);
    ssm_ctrl_t w;
    unique case (step)
      ST_IDLE:   w = '{1'b1, RD_I,    WR_LOAD,     OP_NONE,  C_TAKE_LAST, 1'b1, ST_INIT};
      ST_INIT:   w = '{1'b0, RD_I,    WR_NONE,     OP_INIT,  C_SHORT,     1'b0, ST_EMIT0};
      ST_OUTER:  w = '{1'b0, RD_I,    WR_NONE,     OP_OUTER, C_NEVER,     1'b0, ST_IDLE};
      ST_FETCH:  w = '{1'b0, RD_J,    WR_NONE,     OP_FETCH, C_NEVER,     1'b0, ST_IDLE};
      ST_SCAN:   w = '{1'b0, RD_JNX,  WR_NONE,     OP_SCAN,  C_SCAN_END,  1'b1, ST_SWAP_A};
      ST_SWAP_A: w = '{1'b0, RD_I,    WR_BEST,     OP_NONE,  C_NEVER,     1'b0, ST_IDLE};
      ST_SWAP_B: w = '{1'b0, RD_I,    WR_SWAPBACK, OP_SWAP,  C_MORE,      1'b0, ST_OUTER};
      ST_EMIT0:  w = '{1'b0, RD_K,    WR_NONE,     OP_NONE,  C_NEVER,     1'b0, ST_IDLE};
      ST_EMIT:   w = '{1'b0, RD_EMIT, WR_NONE,     OP_EMIT,  C_EMIT_END,  1'b1, ST_IDLE};
      default:   w = '{1'b0, RD_I,    WR_NONE,     OP_NONE,  C_NEVER,     1'b0, ST_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [32:0] ssm_mag(input logic signed [31:0] x);
    logic [32:0] ext;
    ext = {x[31], x};
    return x[31] ? (33'd0 - ext) : ext;
  endfunction

  // true when cand strictly beats cur under the mode
  function automatic logic ssm_beats(input logic signed [31:0] cand,
                                     input logic signed [31:0] cur,
                                     input logic [1:0]         mode);
    logic r;
    case (mode)
      MODE_DESC:     r = cand > cur;
      MODE_ASC:      r = cand < cur;
      MODE_MAG_DESC: r = ssm_mag(cand) > ssm_mag(cur);
      default:       r = ssm_mag(cand) < ssm_mag(cur);
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/selection_sort_modes_core.sv -----
// Selection sort block: loads signed words one per cycle into a DEPTH-entry store until a word
// marked last, then sorts them in place by selection sort under order_mode and streams them out,
// marking the final one. Sort time is set by the single read port of the element store: the
// scan loop does one read and one compare per cycle. Input is stalled from the last word until
// the final sorted word has been placed in the output register. Words beyond DEPTH are dropped
// but their last mark still ends the set. Control runs from a nine-step microcode table in
// ssm_pkg. The user must write order_mode only while the block is idle; the block itself does
// not enforce it.
module selection_sort_modes_core
  import ssm_pkg::*;
#(
  parameter int DEPTH = SSM_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  ssm_in_t    in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output ssm_out_t   out_data,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ssm_ctrl_t ctl;
  ssm_step_t pc_r, pc_nxt;
  logic [1:0]    mode_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [AW-1:0] choice_r, choice_nxt;
  logic signed [31:0] best_r, best_nxt;
  logic signed [31:0] vi_r, vi_nxt;
  logic     out_valid_r, out_valid_nxt;
  ssm_out_t out_data_r, out_data_nxt;

  logic          in_accept, out_free, jump, store_room;
  logic [CW-1:0] j_inc, k_inc;
  logic [CW:0]   i_plus2;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0]   wr_data, rd_data;
  logic signed [31:0] rd_val;

  assign ctl        = ssm_ucode(pc_r);
  assign in_stall   = !ctl.take;
  assign in_accept  = in_valid && ctl.take;
  assign out_free   = !out_valid_r || !out_stall;
  assign store_room = cnt_r < CW'(DEPTH);
  assign j_inc      = j_r + 1'b1;
  assign k_inc      = k_r + 1'b1;
  assign i_plus2    = (CW+1)'(i_r) + (CW+1)'(2);
  assign rd_val     = $signed(rd_data);

  // sequencer
  always_comb begin
    case (ctl.cond)
      C_TAKE_LAST: jump = in_accept && in_data.last;
      C_SHORT:     jump = cnt_r < CW'(2);
      C_SCAN_END:  jump = j_inc == cnt_r;
      C_MORE:      jump = i_plus2 < (CW+1)'(cnt_r);
      C_EMIT_END:  jump = out_free && (k_inc == cnt_r);
      default:     jump = 1'b0;
    endcase
    if (jump) begin
      pc_nxt = ctl.target;
    end else if (ctl.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  // store ports
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = i_r;
    wr_data = best_r;
    unique case (ctl.wr_sel)
      WR_LOAD: begin
        wr_en   = in_accept && store_room;
        wr_addr = cnt_r[AW-1:0];
        wr_data = in_data.value;
      end
      WR_BEST: begin
        wr_en = 1'b1;
      end
      WR_SWAPBACK: begin
        wr_en   = 1'b1;
        wr_addr = choice_r;
        wr_data = vi_r;
      end
      default: ;
    endcase
    unique case (ctl.rd_sel)
      RD_I:    rd_addr = i_r;
      RD_J:    rd_addr = j_r[AW-1:0];
      RD_JNX:  rd_addr = j_inc[AW-1:0];
      RD_K:    rd_addr = k_r[AW-1:0];
      RD_EMIT: rd_addr = out_free ? k_inc[AW-1:0] : k_r[AW-1:0];
      default: rd_addr = i_r;
    endcase
  end

  // datapath
  always_comb begin
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    choice_nxt    = choice_r;
    best_nxt      = best_r;
    vi_nxt        = vi_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (in_accept && store_room) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    unique case (ctl.op)
      OP_INIT: begin
        i_nxt = '0;
        k_nxt = '0;
      end
      OP_OUTER: begin
        choice_nxt = i_r;
        j_nxt      = CW'(i_r) + 1'b1;
      end
      OP_FETCH: begin
        best_nxt = rd_val;
        vi_nxt   = rd_val;
      end
      OP_SCAN: begin
        // first strict winner is kept, so ties stay with the earlier index
        if (ssm_beats(rd_val, best_r, mode_r)) begin
          best_nxt   = rd_val;
          choice_nxt = j_r[AW-1:0];
        end
        j_nxt = j_inc;
      end
      OP_SWAP: begin
        i_nxt = i_r + 1'b1;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.sorted_value = rd_val;
          out_data_nxt.final_res  = k_inc == cnt_r;
          k_nxt                   = k_inc;
          if (k_inc == cnt_r) begin
            cnt_nxt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= ST_IDLE;
      cnt_r       <= '0;
      mode_r      <= MODE_DESC;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    choice_r   <= choice_nxt;
    best_r     <= best_nxt;
    vi_r       <= vi_nxt;
    out_data_r <= out_data_nxt;
  end

  ssm_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hdl/ssm_ram.sv -----
// ssm_ram: generic single write port, single read port memory with registered read.
// Depends on nothing.
module ssm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/ssm_checker.sv -----
// ssm_checker: port-level assertions for selection_sort_modes_core, bound to the top level.
// Depends on ssm_pkg for the word types.
module ssm_checker
  import ssm_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input ssm_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input ssm_out_t out_data
);

  // a held output word does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  // a word marked last ends loading at once
  a_last_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last |=> in_stall)
    else $error("input taken right after last word");

  // while a set is still being emitted no new word is taken
  a_no_load_mid_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.final_res |-> in_stall)
    else $error("input taken while a sorted set is unfinished");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind selection_sort_modes_core ssm_checker u_ssm_checker (.*);
